// File: src/rrd_pkg.sv
// Package for the request deframer: parse phases, result kinds, status codes,
// byte constants and the result record type. No dependencies.
package rrd_pkg;

  localparam int COUNT_BITS_DEF  = 16;
  localparam int LENGTH_BITS_DEF = 32;

  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 16;
  localparam int TOTAL_W = 17;
  localparam int NUM_W   = 32;
  localparam int MAX_RES = 3;

  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;

  localparam logic [TOTAL_W-1:0] TOKEN_LIMIT = 17'h10000;
  localparam logic [NUM_W-1:0]   POS_LIMIT   = 32'h7FFF_FFFF;
  localparam logic [NUM_W-1:0]   NEG_LIMIT   = 32'h8000_0000;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_MARK    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [1:0] ST_COMPLETE  = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  typedef enum logic [3:0] {
    PH_START, PH_GAP, PH_WORD, PH_CNT0, PH_CNT, PH_CNT_LF, PH_DOLLAR,
    PH_LEN0, PH_LEN, PH_LEN_LF, PH_BODY, PH_SKIP, PH_TRAIL, PH_ERR
  } rrd_phase_t;

  typedef struct packed {
    logic               last;
    logic [1:0]         status;
    logic [TOTAL_W-1:0] total;
    logic [INDEX_W-1:0] index;
    logic [BYTE_W-1:0]  data;
    logic [1:0]         kind;
  } rrd_result_t;

endpackage

// File: src/resp_request_deframer.sv
// Request deframer top level: input register, parser, result register.
// Depends on rrd_pkg, rrd_parser and rrd_resbuf.
// Each item is registered, then its results load into the result register once free.
// Throughput: 1 item per cycle at up to 1 result each while out_tready is high.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to the start of a message with zero tokens.
module resp_request_deframer #(
  parameter int COUNT_BITS  = rrd_pkg::COUNT_BITS_DEF,
  parameter int LENGTH_BITS = rrd_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] token_byte, [23:8] token_index,
                                  // [40:24] token_total, [42:41] status, zero above
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last_result
);

  logic                       in_vld_r, in_vld_nxt;
  logic [rrd_pkg::BYTE_W-1:0] in_byte_r;
  logic                       in_has_r, in_eom_r;
  logic                       in_xfer, adv, free;
  rrd_pkg::rrd_result_t       res [rrd_pkg::MAX_RES];
  logic [1:0]                 res_n;
  rrd_pkg::rrd_result_t       out_res;

  assign in_xfer   = in_tvalid && in_tready;
  assign adv       = in_vld_r && free;
  assign in_tready = !in_vld_r || adv;

  always_comb begin
    if (in_xfer) in_vld_nxt = 1'b1;
    else if (adv) in_vld_nxt = 1'b0;
    else in_vld_nxt = in_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) in_vld_r <= 1'b0;
    else in_vld_r <= in_vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_tdata;
      in_has_r  <= in_tuser;
      in_eom_r  <= in_tlast;
    end
  end

  rrd_parser #(
    .COUNT_BITS  (COUNT_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .data_byte      (in_byte_r),
    .has_byte       (in_has_r),
    .end_of_message (in_eom_r),
    .res            (res),
    .res_n          (res_n)
  );

  rrd_resbuf u_resbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .res       (res),
    .res_n     (res_n),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_res   (out_res),
    .free      (free)
  );

  assign out_tdata = {5'b0, out_res.status, out_res.total, out_res.index, out_res.data};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == rrd_pkg::KIND_SUMMARY |-> out_tlast)
    else $error("summary result not marked last");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_n != 2'd0 |=> out_tvalid)
    else $error("loaded results not presented");

  a_full_stage_adv: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_vld_r |-> adv)
    else $error("input register overwritten");

  a_eom_summary: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_eom_r |-> res_n != 2'd0)
    else $error("message end without summary");

endmodule

// File: src/rrd_parser.sv
// Parser state and per-item logic: one registered input item in, up to three
// result records out. Depends on rrd_pkg.
module rrd_parser #(
  parameter int COUNT_BITS  = rrd_pkg::COUNT_BITS_DEF,
  parameter int LENGTH_BITS = rrd_pkg::LENGTH_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic [rrd_pkg::BYTE_W-1:0]         data_byte,
  input  logic                               has_byte,
  input  logic                               end_of_message,
  output rrd_pkg::rrd_result_t               res [rrd_pkg::MAX_RES],
  output logic [1:0]                         res_n
);

  localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;
  localparam logic [32:0] LEN_MAX = (33'd1 << LENGTH_BITS) - 33'd1;

  rrd_pkg::rrd_phase_t              phase_r, phase_nxt, b_phase;
  logic [COUNT_BITS-1:0]            elem_r, elem_nxt, b_elem;
  logic [LENGTH_BITS-1:0]           blen_r, blen_nxt, b_blen;
  logic [rrd_pkg::NUM_W-1:0]        acc_r, acc_nxt, b_acc;
  logic                             neg_r, neg_nxt, b_neg;
  logic                             dig_r, dig_nxt, b_dig;
  logic [rrd_pkg::TOTAL_W-1:0]      td_r, td_nxt, b_td;
  logic [1:0]                       skip_r, skip_nxt, b_skip;
  logic [1:0]                       ms_r, ms_nxt, b_ms;
  logic                             emit_tok, emit_mark;

  logic [rrd_pkg::BYTE_W-1:0]       b;
  logic                             is_space, is_digit, is_sign, first, in_range;
  logic                             at_limit, len_bad;
  logic [35:0]                      acc10;
  logic [rrd_pkg::NUM_W-1:0]        acc_sat;
  logic [1:0]                       sum_st;
  logic                             end_word;

  assign b        = data_byte;
  assign is_space = b inside {rrd_pkg::CH_SPACE, [rrd_pkg::CH_TAB:rrd_pkg::CH_CR]};
  assign is_digit = b inside {[rrd_pkg::CH_ZERO:rrd_pkg::CH_NINE]};
  assign is_sign  = (b == rrd_pkg::CH_PLUS) || (b == rrd_pkg::CH_MINUS);
  assign first    = (phase_r == rrd_pkg::PH_CNT0) || (phase_r == rrd_pkg::PH_LEN0);
  assign acc10    = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {32'b0, b[3:0]};
  assign acc_sat  = (|acc10[35:32]) ? '1 : acc10[31:0];
  assign in_range = neg_r ? (acc_r <= rrd_pkg::NEG_LIMIT) : (acc_r <= rrd_pkg::POS_LIMIT);
  assign at_limit = td_r >= rrd_pkg::TOKEN_LIMIT;
  assign len_bad  = (b != rrd_pkg::CH_LF) || !in_range || (neg_r && acc_r != '0) ||
                    ({1'b0, acc_r} > LEN_MAX);

  // byte step
  always_comb begin
    b_phase = phase_r; b_elem = elem_r; b_blen = blen_r; b_acc = acc_r;
    b_neg = neg_r; b_dig = dig_r; b_td = td_r; b_skip = skip_r; b_ms = ms_r;
    emit_tok = 1'b0; emit_mark = 1'b0;
    if (has_byte) begin
      case (phase_r)
        rrd_pkg::PH_START, rrd_pkg::PH_GAP: begin
          if (phase_r == rrd_pkg::PH_START && b == rrd_pkg::CH_STAR) begin
            b_acc = '0; b_neg = 1'b0; b_dig = 1'b0;
            b_phase = rrd_pkg::PH_CNT0;
          end else if (is_space) begin
            b_phase = rrd_pkg::PH_GAP;
          end else if (at_limit) begin
            b_ms = rrd_pkg::ST_MALFORMED; b_phase = rrd_pkg::PH_ERR;
          end else begin
            emit_tok = 1'b1; b_phase = rrd_pkg::PH_WORD;
          end
        end
        rrd_pkg::PH_WORD: begin
          if (is_space) begin
            emit_mark = 1'b1; b_td = td_r + 1'b1; b_phase = rrd_pkg::PH_GAP;
          end else begin
            emit_tok = 1'b1;
          end
        end
        rrd_pkg::PH_CNT0, rrd_pkg::PH_CNT, rrd_pkg::PH_LEN0, rrd_pkg::PH_LEN: begin
          if (is_digit) begin
            b_acc = acc_sat; b_dig = 1'b1;
            b_phase = (phase_r == rrd_pkg::PH_CNT0 || phase_r == rrd_pkg::PH_CNT) ?
                      rrd_pkg::PH_CNT : rrd_pkg::PH_LEN;
          end else if (first && is_sign) begin
            b_neg = (b == rrd_pkg::CH_MINUS);
            b_phase = (phase_r == rrd_pkg::PH_CNT0) ? rrd_pkg::PH_CNT : rrd_pkg::PH_LEN;
          end else if (b == rrd_pkg::CH_CR && dig_r) begin
            b_phase = (phase_r == rrd_pkg::PH_CNT0 || phase_r == rrd_pkg::PH_CNT) ?
                      rrd_pkg::PH_CNT_LF : rrd_pkg::PH_LEN_LF;
          end else begin
            b_ms = rrd_pkg::ST_MALFORMED; b_phase = rrd_pkg::PH_ERR;
          end
        end
        rrd_pkg::PH_CNT_LF: begin
          if (b != rrd_pkg::CH_LF || !in_range) begin
            b_ms = rrd_pkg::ST_MALFORMED; b_phase = rrd_pkg::PH_ERR;
          end else begin
            if (neg_r) b_elem = '0;
            else if ({1'b0, acc_r} > CNT_MAX) b_elem = CNT_MAX[COUNT_BITS-1:0];
            else b_elem = acc_r[COUNT_BITS-1:0];
            b_phase = (b_elem != '0) ? rrd_pkg::PH_DOLLAR : rrd_pkg::PH_TRAIL;
          end
        end
        rrd_pkg::PH_DOLLAR: begin
          if (b != rrd_pkg::CH_DOLLAR || at_limit) begin
            b_ms = rrd_pkg::ST_MALFORMED; b_phase = rrd_pkg::PH_ERR;
          end else begin
            b_acc = '0; b_neg = 1'b0; b_dig = 1'b0; b_phase = rrd_pkg::PH_LEN0;
          end
        end
        rrd_pkg::PH_LEN_LF: begin
          if (len_bad) begin
            b_ms = rrd_pkg::ST_MALFORMED; b_phase = rrd_pkg::PH_ERR;
          end else begin
            b_blen = acc_r[LENGTH_BITS-1:0];
            if (acc_r == '0) begin
              emit_mark = 1'b1; b_td = td_r + 1'b1;
              b_elem = (elem_r != '0) ? elem_r - 1'b1 : elem_r;
              b_skip = 2'd2; b_phase = rrd_pkg::PH_SKIP;
            end else begin
              b_phase = rrd_pkg::PH_BODY;
            end
          end
        end
        rrd_pkg::PH_BODY: begin
          emit_tok = 1'b1;
          b_blen = blen_r - 1'b1;
          if (b_blen == '0) begin
            emit_mark = 1'b1; b_td = td_r + 1'b1;
            b_elem = (elem_r != '0) ? elem_r - 1'b1 : elem_r;
            b_skip = 2'd2; b_phase = rrd_pkg::PH_SKIP;
          end
        end
        rrd_pkg::PH_SKIP: begin
          b_skip = (skip_r != 2'd0) ? skip_r - 2'd1 : skip_r;
          if (b_skip == 2'd0)
            b_phase = (elem_r != '0) ? rrd_pkg::PH_DOLLAR : rrd_pkg::PH_TRAIL;
        end
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    if (end_of_message) begin
      phase_nxt = rrd_pkg::PH_START; elem_nxt = '0; blen_nxt = '0; acc_nxt = '0;
      neg_nxt = 1'b0; dig_nxt = 1'b0; td_nxt = '0; skip_nxt = 2'd0;
      ms_nxt = rrd_pkg::ST_COMPLETE;
    end else begin
      phase_nxt = b_phase; elem_nxt = b_elem; blen_nxt = b_blen; acc_nxt = b_acc;
      neg_nxt = b_neg; dig_nxt = b_dig; td_nxt = b_td; skip_nxt = b_skip;
      ms_nxt = b_ms;
    end
  end

  // results
  assign end_word = (b_phase == rrd_pkg::PH_WORD);

  always_comb begin
    if (b_ms != rrd_pkg::ST_COMPLETE) begin
      sum_st = b_ms;
    end else begin
      case (b_phase)
        rrd_pkg::PH_CNT0, rrd_pkg::PH_CNT, rrd_pkg::PH_CNT_LF, rrd_pkg::PH_DOLLAR,
        rrd_pkg::PH_LEN0, rrd_pkg::PH_LEN, rrd_pkg::PH_LEN_LF, rrd_pkg::PH_BODY:
          sum_st = rrd_pkg::ST_TRUNCATED;
        rrd_pkg::PH_SKIP:
          sum_st = (b_elem != '0) ? rrd_pkg::ST_TRUNCATED : rrd_pkg::ST_COMPLETE;
        default:
          sum_st = rrd_pkg::ST_COMPLETE;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < rrd_pkg::MAX_RES; i++) res[i] = '0;
    res_n = 2'd0;
    if (emit_tok) begin
      res[res_n].kind  = rrd_pkg::KIND_BYTE;
      res[res_n].data  = b;
      res[res_n].index = td_r[rrd_pkg::INDEX_W-1:0];
      res_n = res_n + 2'd1;
    end
    if (emit_mark) begin
      res[res_n].kind  = rrd_pkg::KIND_MARK;
      res[res_n].index = td_r[rrd_pkg::INDEX_W-1:0];
      res_n = res_n + 2'd1;
    end
    if (end_of_message) begin
      if (end_word) begin
        res[res_n].kind  = rrd_pkg::KIND_MARK;
        res[res_n].index = b_td[rrd_pkg::INDEX_W-1:0];
        res_n = res_n + 2'd1;
      end
      res[res_n].kind   = rrd_pkg::KIND_SUMMARY;
      res[res_n].total  = b_td + {16'b0, end_word};
      res[res_n].status = sum_st;
      res_n = res_n + 2'd1;
    end
    if (res_n != 2'd0) res[res_n - 2'd1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rrd_pkg::PH_START; elem_r <= '0; blen_r <= '0; acc_r <= '0;
      neg_r <= 1'b0; dig_r <= 1'b0; td_r <= '0; skip_r <= 2'd0;
      ms_r <= rrd_pkg::ST_COMPLETE;
    end else if (adv) begin
      phase_r <= phase_nxt; elem_r <= elem_nxt; blen_r <= blen_nxt; acc_r <= acc_nxt;
      neg_r <= neg_nxt; dig_r <= dig_nxt; td_r <= td_nxt; skip_r <= skip_nxt;
      ms_r <= ms_nxt;
    end
  end

endmodule

// File: src/rrd_resbuf.sv
// Result register: holds the up to three results of one item and shifts
// them out one transfer at a time. Depends on rrd_pkg.
module rrd_resbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  rrd_pkg::rrd_result_t res [rrd_pkg::MAX_RES],
  input  logic [1:0]           res_n,
  input  logic                 out_ready,
  output logic                 out_valid,
  output rrd_pkg::rrd_result_t out_res,
  output logic                 free
);

  rrd_pkg::rrd_result_t ent_r [rrd_pkg::MAX_RES];
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = ent_r[0];
  assign pop       = out_valid && out_ready;
  assign free      = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);

  always_comb begin
    if (load) cnt_nxt = res_n;
    else if (pop) cnt_nxt = cnt_r - 2'd1;
    else cnt_nxt = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 2'd0;
    else cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= res;
    end else if (pop) begin
      ent_r[0] <= ent_r[1];
      ent_r[1] <= ent_r[2];
    end
  end

endmodule

// File: sim/resp_request_deframer_tb.sv
// Testbench for resp_request_deframer: directed message table, then random
// RESP, whitespace and noise messages, checked against a behavioral parser.
// Depends on rrd_pkg and the RTL of resp_request_deframer.
module resp_request_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT  = 20_000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          RAND_ITEMS   = 60;
  localparam logic [63:0] CNT_MAX      = (64'd1 << rrd_pkg::COUNT_BITS_DEF) - 64'd1;
  localparam logic [63:0] LEN_MAX      = (64'd1 << rrd_pkg::LENGTH_BITS_DEF) - 64'd1;
  localparam int          DIR_N        = 25;

  typedef enum {NUM_TAKEN, NUM_CR_SEEN, NUM_BAD} num_res_t;

  typedef struct packed {
    logic                        typed;
    logic [rrd_pkg::TOTAL_W-1:0] total;
    logic [1:0]                  status;
  } summary_t;

  typedef struct packed {
    logic                        end_empty;
    logic                        typed;
    logic [rrd_pkg::TOTAL_W-1:0] total;
    logic [1:0]                  status;
  } dir_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  logic        steady     = 1'b0;
  int          fail_cnt   = 0;
  int          cycle_cnt  = 0;
  int          item_cnt   = 0;

  // parser state
  rrd_pkg::rrd_phase_t ph;
  logic [31:0] elem_left;
  logic [31:0] body_left;
  logic [31:0] num_acc;
  logic        num_neg;
  logic        num_dig;
  logic [31:0] tok_done;
  logic [1:0]  skip_cnt;
  logic [1:0]  msg_st;

  rrd_pkg::rrd_result_t step_res[$];
  rrd_pkg::rrd_result_t expect_q[$];
  summary_t             summary_q[$];
  logic [7:0]           msg_bytes[$];

  string dir_text [DIR_N] = '{
    "",
    "PING",
    "\tECHO  \013hi\014\015\n x",
    "\377\001 \177\200",
    "*2\015\n$4\015\nECHO\015\n$2\015\nhi\015\n",
    "*0\015\njunk",
    "*-1\015\n$1\015\n",
    "*+1\015\n$0\015\n\015\n",
    "*1\015\n$-0\015\nzz",
    "*1\015\n$3\015\nab",
    "*2\015\n$1\015\na\015",
    "*1\015\n$1\015\nz\015",
    "*3",
    "*1x",
    "*\015\n",
    "* 1\015\n",
    "*1\015x$1",
    "*1\015\n#3\015\nabc",
    "*1\015\n$-2\015\nab",
    "*2147483648\015\n",
    "*-2147483648\015\n$1",
    "*99999999999\015\n",
    "*70000\015\n$0\015\n\015\n",
    "*1\015\n$2147483647\015\nab",
    "x* y"
  };

  dir_row_t dir_rows [DIR_N] = '{
    '{1'b1, 1'b1, 17'd0, rrd_pkg::ST_COMPLETE},
    '{1'b0, 1'b1, 17'd1, rrd_pkg::ST_COMPLETE},
    '{1'b1, 1'b0, 17'd0, rrd_pkg::ST_COMPLETE},
    '{1'b0, 1'b0, 17'd0, rrd_pkg::ST_COMPLETE},
    '{1'b0, 1'b1, 17'd2, rrd_pkg::ST_COMPLETE},
    '{1'b0, 1'b1, 17'd0, rrd_pkg::ST_COMPLETE},
    '{1'b1, 1'b1, 17'd0, rrd_pkg::ST_COMPLETE},
    '{1'b0, 1'b1, 17'd1, rrd_pkg::ST_COMPLETE},
    '{1'b0, 1'b1, 17'd1, rrd_pkg::ST_COMPLETE},
    '{1'b1, 1'b1, 17'd0, rrd_pkg::ST_TRUNCATED},
    '{1'b0, 1'b1, 17'd1, rrd_pkg::ST_TRUNCATED},
    '{1'b1, 1'b1, 17'd1, rrd_pkg::ST_COMPLETE},
    '{1'b0, 1'b1, 17'd0, rrd_pkg::ST_TRUNCATED},
    '{1'b0, 1'b1, 17'd0, rrd_pkg::ST_MALFORMED},
    '{1'b1, 1'b1, 17'd0, rrd_pkg::ST_MALFORMED},
    '{1'b0, 1'b1, 17'd0, rrd_pkg::ST_MALFORMED},
    '{1'b0, 1'b1, 17'd0, rrd_pkg::ST_MALFORMED},
    '{1'b0, 1'b1, 17'd0, rrd_pkg::ST_MALFORMED},
    '{1'b1, 1'b1, 17'd0, rrd_pkg::ST_MALFORMED},
    '{1'b0, 1'b1, 17'd0, rrd_pkg::ST_MALFORMED},
    '{1'b0, 1'b1, 17'd0, rrd_pkg::ST_COMPLETE},
    '{1'b1, 1'b1, 17'd0, rrd_pkg::ST_MALFORMED},
    '{1'b0, 1'b1, 17'd1, rrd_pkg::ST_TRUNCATED},
    '{1'b1, 1'b0, 17'd0, rrd_pkg::ST_COMPLETE},
    '{1'b0, 1'b0, 17'd0, rrd_pkg::ST_COMPLETE}
  };

  resp_request_deframer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit is_ws(logic [7:0] b);
    return b == rrd_pkg::CH_SPACE || (b >= rrd_pkg::CH_TAB && b <= rrd_pkg::CH_CR);
  endfunction

  function automatic void add_result(logic [1:0] k, logic [7:0] b, logic [31:0] idx,
                                     logic [31:0] tot, logic [1:0] st);
    rrd_pkg::rrd_result_t r;
    r.kind   = k;
    r.data   = b;
    r.index  = idx[rrd_pkg::INDEX_W-1:0];
    r.total  = tot[rrd_pkg::TOTAL_W-1:0];
    r.status = st;
    r.last   = 1'b0;
    step_res.insert(step_res.size(), r);
  endfunction

  function automatic void clear_num();
    num_acc = '0;
    num_neg = 1'b0;
    num_dig = 1'b0;
  endfunction

  function automatic void clear_msg();
    ph        = rrd_pkg::PH_START;
    elem_left = '0;
    body_left = '0;
    tok_done  = '0;
    skip_cnt  = '0;
    msg_st    = rrd_pkg::ST_COMPLETE;
    clear_num();
  endfunction

  function automatic void set_malformed();
    msg_st = rrd_pkg::ST_MALFORMED;
    ph     = rrd_pkg::PH_ERR;
  endfunction

  function automatic void close_token();
    add_result(rrd_pkg::KIND_MARK, 8'h00, tok_done, 32'd0, rrd_pkg::ST_COMPLETE);
    tok_done++;
  endfunction

  function automatic num_res_t digit_step(logic [7:0] b, bit first);
    logic [35:0] v;
    if (b >= rrd_pkg::CH_ZERO && b <= rrd_pkg::CH_NINE) begin
      v = num_acc * 36'd10 + 36'(b - rrd_pkg::CH_ZERO);
      num_acc = (v > 36'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
      num_dig = 1'b1;
      return NUM_TAKEN;
    end
    if (first && (b == rrd_pkg::CH_PLUS || b == rrd_pkg::CH_MINUS)) begin
      num_neg = (b == rrd_pkg::CH_MINUS);
      return NUM_TAKEN;
    end
    if (b == rrd_pkg::CH_CR && num_dig) return NUM_CR_SEEN;
    return NUM_BAD;
  endfunction

  function automatic bit num_ok();
    return num_acc <= (num_neg ? rrd_pkg::NEG_LIMIT : rrd_pkg::POS_LIMIT);
  endfunction

  function automatic void finish_element();
    close_token();
    if (elem_left != 0) elem_left--;
    skip_cnt = 2'd2;
    ph       = rrd_pkg::PH_SKIP;
  endfunction

  function automatic void word_step(logic [7:0] b);
    if (ph == rrd_pkg::PH_WORD) begin
      if (is_ws(b)) begin
        close_token();
        ph = rrd_pkg::PH_GAP;
      end else begin
        add_result(rrd_pkg::KIND_BYTE, b, tok_done, 32'd0, rrd_pkg::ST_COMPLETE);
      end
    end else if (is_ws(b)) begin
      ph = rrd_pkg::PH_GAP;
    end else if (tok_done >= 32'(rrd_pkg::TOKEN_LIMIT)) begin
      set_malformed();
    end else begin
      add_result(rrd_pkg::KIND_BYTE, b, tok_done, 32'd0, rrd_pkg::ST_COMPLETE);
      ph = rrd_pkg::PH_WORD;
    end
  endfunction

  function automatic void byte_step(logic [7:0] b);
    num_res_t r;
    case (ph)
      rrd_pkg::PH_START: begin
        if (b == rrd_pkg::CH_STAR) begin
          clear_num();
          ph = rrd_pkg::PH_CNT0;
        end else begin
          word_step(b);
        end
      end
      rrd_pkg::PH_GAP, rrd_pkg::PH_WORD: word_step(b);
      rrd_pkg::PH_CNT0, rrd_pkg::PH_CNT: begin
        r = digit_step(b, ph == rrd_pkg::PH_CNT0);
        if (r == NUM_BAD) set_malformed();
        else ph = (r == NUM_CR_SEEN) ? rrd_pkg::PH_CNT_LF : rrd_pkg::PH_CNT;
      end
      rrd_pkg::PH_CNT_LF: begin
        if (b != rrd_pkg::CH_LF || !num_ok()) begin
          set_malformed();
        end else begin
          if (num_neg) elem_left = '0;
          else elem_left = (64'(num_acc) > CNT_MAX) ? CNT_MAX[31:0] : num_acc;
          ph = (elem_left != 0) ? rrd_pkg::PH_DOLLAR : rrd_pkg::PH_TRAIL;
        end
      end
      rrd_pkg::PH_DOLLAR: begin
        if (b != rrd_pkg::CH_DOLLAR || tok_done >= 32'(rrd_pkg::TOKEN_LIMIT)) begin
          set_malformed();
        end else begin
          clear_num();
          ph = rrd_pkg::PH_LEN0;
        end
      end
      rrd_pkg::PH_LEN0, rrd_pkg::PH_LEN: begin
        r = digit_step(b, ph == rrd_pkg::PH_LEN0);
        if (r == NUM_BAD) set_malformed();
        else ph = (r == NUM_CR_SEEN) ? rrd_pkg::PH_LEN_LF : rrd_pkg::PH_LEN;
      end
      rrd_pkg::PH_LEN_LF: begin
        if (b != rrd_pkg::CH_LF || !num_ok() || (num_neg && num_acc != 0) ||
            64'(num_acc) > LEN_MAX) begin
          set_malformed();
        end else begin
          body_left = num_acc;
          if (body_left == 0) finish_element();
          else ph = rrd_pkg::PH_BODY;
        end
      end
      rrd_pkg::PH_BODY: begin
        add_result(rrd_pkg::KIND_BYTE, b, tok_done, 32'd0, rrd_pkg::ST_COMPLETE);
        body_left--;
        if (body_left == 0) finish_element();
      end
      rrd_pkg::PH_SKIP: begin
        if (skip_cnt != 0) skip_cnt--;
        if (skip_cnt == 0) ph = (elem_left != 0) ? rrd_pkg::PH_DOLLAR : rrd_pkg::PH_TRAIL;
      end
      default: ;
    endcase
  endfunction

  function automatic void end_step();
    logic [1:0] st;
    summary_t   ov;
    if (ph == rrd_pkg::PH_WORD) close_token();
    if (msg_st != rrd_pkg::ST_COMPLETE) begin
      st = msg_st;
    end else begin
      case (ph)
        rrd_pkg::PH_CNT0, rrd_pkg::PH_CNT, rrd_pkg::PH_CNT_LF, rrd_pkg::PH_DOLLAR,
        rrd_pkg::PH_LEN0, rrd_pkg::PH_LEN, rrd_pkg::PH_LEN_LF, rrd_pkg::PH_BODY:
          st = rrd_pkg::ST_TRUNCATED;
        rrd_pkg::PH_SKIP:
          st = (elem_left != 0) ? rrd_pkg::ST_TRUNCATED : rrd_pkg::ST_COMPLETE;
        default: st = rrd_pkg::ST_COMPLETE;
      endcase
    end
    ov = '0;
    if (summary_q.size() != 0) ov = summary_q.pop_front();
    if (ov.typed) add_result(rrd_pkg::KIND_SUMMARY, 8'h00, 32'd0, 32'(ov.total), ov.status);
    else add_result(rrd_pkg::KIND_SUMMARY, 8'h00, 32'd0, tok_done, st);
    clear_msg();
  endfunction

  function automatic void predict_item(logic [7:0] d, logic has, logic eom);
    step_res.delete();
    if (has) byte_step(d);
    if (eom) end_step();
    if (step_res.size() != 0) step_res[step_res.size()-1].last = 1'b1;
    foreach (step_res[i]) expect_q.insert(expect_q.size(), step_res[i]);
  endfunction

  function automatic void note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s", msg);
  endfunction

  function automatic void add_msg_byte(logic [7:0] v);
    msg_bytes.insert(msg_bytes.size(), v);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) add_msg_byte(s[i]);
  endfunction

  function automatic void push_num_line(int v);
    push_text($sformatf("%0d", v));
    add_msg_byte(rrd_pkg::CH_CR);
    add_msg_byte(rrd_pkg::CH_LF);
  endfunction

  task automatic send_item(logic [7:0] d, logic has, logic eom);
    while (!steady && $urandom_range(0, 99) < 14) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= has;
    in_tlast  <= eom;
    item_cnt++;
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  task automatic send_msg(bit end_empty, bit typed, logic [rrd_pkg::TOTAL_W-1:0] tot,
                          logic [1:0] st);
    summary_t ov;
    int       n;
    ov.typed  = typed;
    ov.total  = tot;
    ov.status = st;
    summary_q.insert(summary_q.size(), ov);
    n = msg_bytes.size();
    if (n == 0) end_empty = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (!steady && $urandom_range(0, 99) < 6) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(msg_bytes[i], 1'b1, !end_empty && i == n - 1);
    end
    if (end_empty) send_item(8'($urandom), 1'b0, 1'b1);
    msg_bytes.delete();
  endtask

  // stall the result side
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 14);
  end

  always @(posedge clk) begin : check_blk
    rrd_pkg::rrd_result_t got;
    rrd_pkg::rrd_result_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAIL");
      $finish;
    end
    if (!rst_n) begin
      clear_msg();
    end else begin
      if (in_tvalid && in_tready) predict_item(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        got.kind   = out_tuser;
        got.data   = out_tdata[7:0];
        got.index  = out_tdata[23:8];
        got.total  = out_tdata[40:24];
        got.status = out_tdata[42:41];
        got.last   = out_tlast;
        if (expect_q.size() == 0) begin
          note_failure($sformatf("unexpected result: kind %0d byte %h index %0d total %0d",
                                 got.kind, got.data, got.index, got.total));
        end else begin
          want = expect_q.pop_front();
          if (got !== want || out_tdata[47:43] != 0) begin
            note_failure($sformatf({"mismatch (exp/got): kind %0d/%0d byte %h/%h ",
                                    "index %0d/%0d total %0d/%0d status %0d/%0d ",
                                    "last %0d/%0d pad %h"},
                                   want.kind, got.kind, want.data, got.data,
                                   want.index, got.index, want.total, got.total,
                                   want.status, got.status, want.last, got.last,
                                   out_tdata[47:43]));
          end
        end
      end
    end
  end

  initial begin : stim_blk
    logic [7:0] b;
    int         n_el;
    int         len;
    int         sel;
    int         cut;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      // run directed rows 4 to 11, complete and truncated RESP arrays, with no idling
      steady = (i >= 4 && i <= 11);
      push_text(dir_text[i]);
      send_msg(dir_rows[i].end_empty, dir_rows[i].typed, dir_rows[i].total,
               dir_rows[i].status);
    end
    steady = 1'b0;

    item_cnt = 0;
    while (item_cnt < RAND_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (sel <= 4) begin
        n_el = $urandom_range(0, 3);
        add_msg_byte(rrd_pkg::CH_STAR);
        if ($urandom_range(0, 9) == 0) add_msg_byte(rrd_pkg::CH_PLUS);
        push_num_line(n_el);
        repeat (n_el) begin
          add_msg_byte(rrd_pkg::CH_DOLLAR);
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
          push_num_line(len);
          repeat (len) add_msg_byte(8'($urandom));
          if ($urandom_range(0, 4) != 0) begin
            add_msg_byte(rrd_pkg::CH_CR);
            add_msg_byte(rrd_pkg::CH_LF);
          end else begin
            add_msg_byte(8'($urandom));
            add_msg_byte(8'($urandom));
          end
        end
        repeat ($urandom_range(0, 2)) add_msg_byte(8'($urandom));
        sel = $urandom_range(0, 9);
        if (sel == 0 && msg_bytes.size() > 1) begin
          // truncate
          cut = $urandom_range(1, msg_bytes.size() - 1);
          while (msg_bytes.size() > cut) msg_bytes.delete(msg_bytes.size() - 1);
        end else if (sel == 1 && msg_bytes.size() > 1) begin
          // corrupt one byte
          msg_bytes[$urandom_range(1, msg_bytes.size() - 1)] = 8'($urandom);
        end
      end else if (sel <= 7) begin
        if ($urandom_range(0, 2) == 0) add_msg_byte(rrd_pkg::CH_SPACE);
        repeat ($urandom_range(1, 4)) begin
          repeat ($urandom_range(1, 4)) begin
            b = 8'($urandom);
            if (is_ws(b)) b = b ^ 8'h40;
            add_msg_byte(b);
          end
          repeat ($urandom_range(1, 2)) begin
            len = $urandom_range(0, 5);
            add_msg_byte(len == 0 ? rrd_pkg::CH_SPACE : rrd_pkg::CH_TAB + 8'(len - 1));
          end
        end
        if ($urandom_range(0, 1) == 0) msg_bytes.delete(msg_bytes.size() - 1);
      end else begin
        if ($urandom_range(0, 1) == 0) add_msg_byte(rrd_pkg::CH_STAR);
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 7))
            0, 1, 2: add_msg_byte(rrd_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            3:       add_msg_byte(rrd_pkg::CH_CR);
            4:       add_msg_byte(rrd_pkg::CH_LF);
            5:       add_msg_byte(rrd_pkg::CH_DOLLAR);
            6:       add_msg_byte(rrd_pkg::CH_MINUS);
            default: add_msg_byte(8'($urandom));
          endcase
        end
      end
      send_msg($urandom_range(0, 1) == 1, 1'b0, '0, rrd_pkg::ST_COMPLETE);
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
